@@ design/ghosted_array_address_generator_defines.svh @@
// Assertion helpers used by the checker file.
`ifndef GHOSTED_ARRAY_ADDRESS_GENERATOR_DEFINES_SVH
`define GHOSTED_ARRAY_ADDRESS_GENERATOR_DEFINES_SVH

// Clocked assertion that is switched off while reset is held.
`define GAAG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked assertion that is also checked during reset.
`define GAAG_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ design/gaag_pkg.sv @@
package gaag_pkg;

  localparam int MAX_DIMS   = 4;
  localparam int IDX_W      = 16;
  localparam int MAG_W      = 16;
  localparam int EXT_W      = 17;
  localparam int VAL_W      = 18;
  localparam int ACC_W      = 68;
  localparam int STR_W      = 65;
  localparam int STR_MUL_W  = 49;
  localparam int FIN_W      = 82;
  localparam int DIV_STEPS  = 2;
  localparam int DIV_CELLS  = MAG_W / DIV_STEPS;
  localparam int ACC_CELLS  = MAX_DIMS;

  typedef enum logic {
    CMD_START = 1'b0,
    CMD_STEP  = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    REG_NUM_DIMS     = 2'd0,
    REG_COLUMN_MAJOR = 2'd1,
    REG_LOCAL_SIZES  = 2'd2,
    REG_GHOST_WIDTHS = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [2:0]  num_dims;
    logic        column_major;
    logic [63:0] local_sizes;
    logic [31:0] ghost_widths;
  } cfg_t;

  // One item inside the remainder cells; slot k is the k-th dimension in stride order.
  typedef struct packed {
    logic [MAX_DIMS-1:0][MAG_W-1:0] mag;
    logic [MAX_DIMS-1:0][MAG_W-1:0] rem;
    logic [MAX_DIMS-1:0]            neg;
    logic [MAX_DIMS-1:0]            wrap;
    logic [MAX_DIMS-1:0][EXT_W-1:0] ext;
    logic [MAX_DIMS-1:0][EXT_W-1:0] size_ghost;
    logic [MAX_DIMS-1:0][EXT_W-1:0] vraw;
    logic [MAX_DIMS-1:0][EXT_W-1:0] factor;
    cmd_t                           cmd;
    logic [IDX_W-1:0]               step;
  } div_item_t;

  // One item inside the accumulate cells; slot 0 belongs to the current cell.
  typedef struct packed {
    logic [MAX_DIMS-1:0][VAL_W-1:0] vfin;
    logic [MAX_DIMS-1:0][EXT_W-1:0] factor;
    logic [ACC_W-1:0]               acc;
    logic [STR_W-1:0]               stride;
    cmd_t                           cmd;
    logic [IDX_W-1:0]               step;
  } acc_item_t;

  function automatic acc_item_t to_acc(input div_item_t d);
    acc_item_t a;
    logic signed [VAL_W-1:0] r;
    logic signed [VAL_W-1:0] sg;
    a.factor = d.factor;
    a.acc    = '0;
    a.stride = STR_W'(1);
    a.cmd    = d.cmd;
    a.step   = d.step;
    for (int k = 0; k < MAX_DIMS; k++) begin
      r  = $signed({2'b00, d.rem[k]});
      sg = $signed({1'b0, d.size_ghost[k]});
      if (!d.wrap[k]) begin
        a.vfin[k] = {d.vraw[k][EXT_W-1], d.vraw[k]};
      end else if (d.neg[k] && (d.rem[k] != '0)) begin
        a.vfin[k] = sg - r;
      end else begin
        a.vfin[k] = r;
      end
    end
    return a;
  endfunction

endpackage

@@ design/gaag_prep_cell.sv @@
module gaag_prep_cell import gaag_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  cfg_t               cfg,
  input  logic               in_valid,
  output logic               in_ready,
  input  cmd_t               in_cmd,
  input  logic [1:0]         in_range_dim,
  input  logic [IDX_W-1:0]   in_step,
  input  logic [MAX_DIMS-1:0][IDX_W-1:0] in_index,
  output logic               out_valid,
  input  logic               out_ready,
  output div_item_t          out_item
);

  logic      valid_r;
  div_item_t item_r, item_nxt;
  logic [2:0] n_used;
  logic [MAX_DIMS-1:0][1:0] dsel;
  logic [MAX_DIMS-1:0]      active;
  logic [MAX_DIMS-1:0][EXT_W-1:0] ext_all;
  logic [MAX_DIMS-1:0]      use_step;

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_item  = item_r;
  assign n_used    = (cfg.num_dims > 3'(MAX_DIMS)) ? 3'(MAX_DIMS) : cfg.num_dims;

  always_comb begin
    item_nxt      = '0;
    item_nxt.cmd  = in_cmd;
    item_nxt.step = in_step;
    for (int k = 0; k < MAX_DIMS; k++) begin
      ext_all[k] = EXT_W'(cfg.local_sizes[16*k +: 16]) +
                   EXT_W'({cfg.ghost_widths[8*k +: 8], 1'b0});
      active[k]  = 3'(k) < n_used;
      dsel[k]    = cfg.column_major ? 2'(k) : 2'(n_used - 3'(1) - 3'(k));
      use_step[k] = active[k] &&
                    (cfg.column_major ? (2'(k) < in_range_dim) : (2'(k) > in_range_dim));
    end
    for (int k = 0; k < MAX_DIMS; k++) begin
      if (in_cmd == CMD_STEP) begin
        item_nxt.factor[k] = use_step[k] ? ext_all[k] : EXT_W'(1);
      end else if (active[k]) begin
        item_nxt.factor[k]     = ext_all[dsel[k]];
        item_nxt.ext[k]        = ext_all[dsel[k]];
        item_nxt.size_ghost[k] = EXT_W'(cfg.local_sizes[16*dsel[k] +: 16]) +
                                 EXT_W'(cfg.ghost_widths[8*dsel[k] +: 8]);
        item_nxt.vraw[k]       = EXT_W'($signed(in_index[dsel[k]])) +
                                 EXT_W'(cfg.ghost_widths[8*dsel[k] +: 8]);
        item_nxt.neg[k]        = item_nxt.vraw[k][EXT_W-1];
        item_nxt.mag[k]        = item_nxt.neg[k] ? MAG_W'(-item_nxt.vraw[k])
                                                 : MAG_W'(item_nxt.vraw[k]);
        item_nxt.wrap[k]       = (dsel[k] != in_range_dim) && (ext_all[dsel[k]] != '0);
      end else begin
        item_nxt.factor[k] = EXT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= item_nxt;
    end
  end

endmodule

@@ design/gaag_div_cell.sv @@
module gaag_div_cell import gaag_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  div_item_t in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output div_item_t out_item
);

  logic      valid_r;
  div_item_t item_r, item_nxt;
  logic [EXT_W-1:0] r;

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_item  = item_r;

  // Two restoring steps per cell on every dimension in parallel.
  always_comb begin
    item_nxt = in_item;
    r        = '0;
    for (int k = 0; k < MAX_DIMS; k++) begin
      for (int s = 0; s < DIV_STEPS; s++) begin
        r = {item_nxt.rem[k], item_nxt.mag[k][MAG_W-1]};
        item_nxt.mag[k] = {item_nxt.mag[k][MAG_W-2:0], 1'b0};
        if (r >= in_item.ext[k]) begin
          r = r - in_item.ext[k];
        end
        item_nxt.rem[k] = r[MAG_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= item_nxt;
    end
  end

endmodule

@@ design/gaag_acc_cell.sv @@
module gaag_acc_cell import gaag_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  acc_item_t in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output acc_item_t out_item
);

  logic      valid_r;
  acc_item_t item_r, item_nxt;
  logic signed [ACC_W-1:0] prod;
  logic [STR_MUL_W+EXT_W-1:0] sprod;

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_item  = item_r;

  // The stride entering any cell that adds a term holds at most three extents.
  assign prod  = ACC_W'($signed({1'b0, in_item.stride[STR_MUL_W-1:0]}) *
                        $signed(in_item.vfin[0]));
  assign sprod = in_item.stride[STR_MUL_W-1:0] * in_item.factor[0];

  always_comb begin
    item_nxt        = in_item;
    item_nxt.acc    = in_item.acc + prod;
    item_nxt.stride = STR_W'(sprod);
    for (int k = 0; k < MAX_DIMS - 1; k++) begin
      item_nxt.vfin[k]   = in_item.vfin[k+1];
      item_nxt.factor[k] = in_item.factor[k+1];
    end
    item_nxt.vfin[MAX_DIMS-1]   = '0;
    item_nxt.factor[MAX_DIMS-1] = EXT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= item_nxt;
    end
  end

endmodule

@@ design/gaag_out_cell.sv @@
module gaag_out_cell import gaag_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  acc_item_t   in_item,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_offset,
  output logic        out_overflow
);

  logic        valid_r;
  logic [31:0] offset_r;
  logic        overflow_r;
  logic signed [FIN_W-1:0] res;

  assign in_ready     = !valid_r || out_ready;
  assign out_valid    = valid_r;
  assign out_offset   = offset_r;
  assign out_overflow = overflow_r;

  always_comb begin
    if (in_item.cmd == CMD_STEP) begin
      res = FIN_W'($signed({1'b0, in_item.stride}) * $signed(in_item.step));
    end else begin
      res = FIN_W'($signed(in_item.acc));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      offset_r   <= res[31:0];
      overflow_r <= !((&res[FIN_W-1:31]) || !(|res[FIN_W-1:31]));
    end
  end

endmodule

@@ design/ghosted_array_address_generator.sv @@
// Ghosted array address generator.
// Input channel (in_valid/in_ready) takes one item per ready cycle: a command
// (start position or step), the range dimension, a base step and four
// indices. Output channel (out_valid/out_ready) returns one item for each
// input item, in order: the low 32 bits of the offset and an overflow flag.
// Configuration is written through cfg_we/cfg_index/cfg_wdata while idle.
// The datapath is a chain of cells: one preparation cell, eight remainder
// cells doing two restoring division steps each for all dimensions, four
// accumulate cells (one per dimension, one stride multiplier each) and an
// output cell holding the final multiply and the result register.
// Each cell registers the item once; throughput is one item per cycle
// while out_ready stays high, as every cell can advance once per clock.
// Each cell holds its item when the next one cannot take it, so a stalled
// receiver backs up the chain cell by cell and empty cells keep accepting.
// Reset (synchronous, rst_n low) empties every cell and restores the
// registers: one dimension, row-major order, zero sizes and ghost widths.
module ghosted_array_address_generator import gaag_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_command,
  input  logic [1:0]  in_range_dim,
  input  logic signed [15:0] in_step_in,
  input  logic signed [15:0] in_index_0,
  input  logic signed [15:0] in_index_1,
  input  logic signed [15:0] in_index_2,
  input  logic signed [15:0] in_index_3,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [31:0] out_offset,
  output logic        out_overflow,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_wdata
);

  cfg_t cfg_r;

  // Configuration registers; write only while chain is empty (unenforced).
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.num_dims     <= 3'd1;
      cfg_r.column_major <= 1'b0;
      cfg_r.local_sizes  <= '0;
      cfg_r.ghost_widths <= '0;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_NUM_DIMS:     cfg_r.num_dims     <= cfg_wdata[2:0];
        REG_COLUMN_MAJOR: cfg_r.column_major <= cfg_wdata[0];
        REG_LOCAL_SIZES:  cfg_r.local_sizes  <= cfg_wdata;
        REG_GHOST_WIDTHS: cfg_r.ghost_widths <= cfg_wdata[31:0];
        default: ;
      endcase
    end
  end

  logic [MAX_DIMS-1:0][IDX_W-1:0] idx;
  assign idx = {in_index_3, in_index_2, in_index_1, in_index_0};

  // Remainder chain: position 0 is the preparation cell.
  logic      dv [DIV_CELLS+1];
  logic      dr [DIV_CELLS+1];
  div_item_t di [DIV_CELLS+1];

  gaag_prep_cell u_prep (
    .clk, .rst_n, .cfg(cfg_r),
    .in_valid, .in_ready,
    .in_cmd(cmd_t'(in_command)), .in_range_dim,
    .in_step(in_step_in), .in_index(idx),
    .out_valid(dv[0]), .out_ready(dr[0]), .out_item(di[0])
  );

  for (genvar g = 0; g < DIV_CELLS; g++) begin : g_div
    gaag_div_cell u_div (
      .clk, .rst_n,
      .in_valid(dv[g]), .in_ready(dr[g]), .in_item(di[g]),
      .out_valid(dv[g+1]), .out_ready(dr[g+1]), .out_item(di[g+1])
    );
  end

  // Accumulate chain: position 0 is the remainder chain's result with the
  // ghost correction applied.
  logic      av [ACC_CELLS+1];
  logic      ar [ACC_CELLS+1];
  acc_item_t ai [ACC_CELLS+1];

  assign av[0]         = dv[DIV_CELLS];
  assign dr[DIV_CELLS] = ar[0];
  assign ai[0]         = to_acc(di[DIV_CELLS]);

  for (genvar g = 0; g < ACC_CELLS; g++) begin : g_acc
    gaag_acc_cell u_acc (
      .clk, .rst_n,
      .in_valid(av[g]), .in_ready(ar[g]), .in_item(ai[g]),
      .out_valid(av[g+1]), .out_ready(ar[g+1]), .out_item(ai[g+1])
    );
  end

  gaag_out_cell u_out (
    .clk, .rst_n,
    .in_valid(av[ACC_CELLS]), .in_ready(ar[ACC_CELLS]), .in_item(ai[ACC_CELLS]),
    .out_valid, .out_ready, .out_offset, .out_overflow
  );

endmodule

@@ design/gaag_checker.sv @@
`include "ghosted_array_address_generator_defines.svh"

module gaag_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_offset,
  input logic        out_overflow
);

  // A result held back by the receiver stays put.
  `GAAG_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_offset) && $stable(out_overflow), "stalled result changed")

  // Leaving reset, no result is pending.
  `GAAG_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid, "result pending after reset")

  // Leaving reset, the chain is empty and takes an item at once.
  `GAAG_ASSERT_ALWAYS(a_reset_ready, !rst_n |=> in_ready, "input not ready after reset")

endmodule

bind ghosted_array_address_generator gaag_checker u_gaag_checker (
  .clk, .rst_n, .in_ready, .out_valid, .out_ready, .out_offset, .out_overflow
);

@@ dv/ghosted_array_address_generator_test.sv @@
module ghosted_array_address_generator_test;
  import gaag_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Pipeline depth from acceptance to out_valid, plus some slack.
  localparam int LATENCY   = 14;
  localparam int DRAIN_GAP = LATENCY + 6;
  localparam int IDLE_LIMIT = 5000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic        in_command;
  logic [1:0]  in_range_dim;
  logic signed [15:0] in_step_in;
  logic signed [15:0] in_index_0;
  logic signed [15:0] in_index_1;
  logic signed [15:0] in_index_2;
  logic signed [15:0] in_index_3;
  logic        out_valid;
  logic        out_ready;
  logic signed [31:0] out_offset;
  logic        out_overflow;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [63:0] cfg_wdata;

  ghosted_array_address_generator dut (.*);

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Shadow copy of the configuration registers.
  logic [2:0]  dims_reg;
  logic        colmaj_reg;
  logic [63:0] sizes_reg;
  logic [31:0] ghosts_reg;

  typedef struct {
    logic [31:0] offset;
    logic        overflow;
  } offset_t;

  offset_t pending_offsets[$];
  int  error_count;
  int  idle_cycles;

  // Receiver control: long hold-off requested by a test task.
  int  holdoff_request;
  int  holdoff_left;
  bit  stall_pattern_on;

  // Sender pacing.
  int  burst_left;

  // The exact result fits comfortably in 128 signed bits: extents are at most
  // 17 bits wide, four of them plus a 17-bit value stay below 90 bits.
  function automatic offset_t predict_offset(cmd_t cmd, logic [1:0] rdim,
                                             logic signed [15:0] step,
                                             logic signed [15:0] idx[4]);
    logic signed [127:0] acc;
    logic signed [127:0] stride;
    logic signed [31:0]  sz, gh, ext, v, rem;
    int n, d;
    offset_t r;
    n = (dims_reg > 3'd4) ? 4 : int'(dims_reg);
    if (cmd == CMD_START) begin
      acc = 0;
      stride = 1;
      for (int k = 0; k < n; k++) begin
        d   = colmaj_reg ? k : (n - 1 - k);
        sz  = $signed({16'd0, sizes_reg[16*d +: 16]});
        gh  = $signed({24'd0, ghosts_reg[8*d +: 8]});
        ext = sz + 2 * gh;
        v   = 32'(idx[d]) + gh;
        if (d != int'(rdim) && ext > 0) begin
          // SystemVerilog % truncates toward zero like C.
          rem = v % ext;
          v = (rem >= 0) ? rem : sz + gh + rem;
        end
        acc = acc + stride * 128'(v);
        stride = stride * 128'(ext);
      end
    end else begin
      acc = 128'(step);
      for (int k = 0; k < n; k++) begin
        if (colmaj_reg ? (k < int'(rdim)) : (k > int'(rdim))) begin
          sz  = $signed({16'd0, sizes_reg[16*k +: 16]});
          gh  = $signed({24'd0, ghosts_reg[8*k +: 8]});
          acc = acc * 128'(sz + 2 * gh);
        end
      end
    end
    r.offset   = acc[31:0];
    r.overflow = (acc < -128'sd2147483648) || (acc > 128'sd2147483647);
    return r;
  endfunction

  // Receiver: stalls on a fixed-density random pattern when enabled, with an
  // optional long hold-off counted here so the pipeline backs up into the input.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      holdoff_left <= 0;
    end else if (holdoff_request > 0 && holdoff_left == 0) begin
      holdoff_left <= holdoff_request;
      holdoff_request = 0;
      out_ready <= 1'b0;
    end else if (holdoff_left > 0) begin
      holdoff_left <= holdoff_left - 1;
      out_ready <= (holdoff_left == 1);
    end else if (stall_pattern_on) begin
      out_ready <= ($urandom_range(0, 3) != 0);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Result checker and watchdog.
  always @(posedge clk) begin
    offset_t exp_r;
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles > IDLE_LIMIT) begin
        $display("ghosted_array_address_generator_test: done, errors");
        $finish;
      end
      if (out_valid && out_ready) begin
        if (pending_offsets.size() == 0) begin
          $error("result item with nothing expected: offset %0d", out_offset);
          error_count++;
        end else begin
          exp_r = pending_offsets.pop_front();
          if (out_offset !== exp_r.offset) begin
            $error("offset: expected %0d, got %0d", $signed(exp_r.offset), out_offset);
            error_count++;
          end
          if (out_overflow !== exp_r.overflow) begin
            $error("overflow: expected %0b, got %0b", exp_r.overflow, out_overflow);
            error_count++;
          end
        end
      end
    end
  end

  // Sends one item; the expectation is queued at the acceptance edge.
  // Gaps between bursts are inserted before raising valid.
  task automatic send_item(cmd_t cmd, logic [1:0] rdim, logic signed [15:0] step,
                           logic signed [15:0] i0, logic signed [15:0] i1,
                           logic signed [15:0] i2, logic signed [15:0] i3);
    logic signed [15:0] idx[4];
    int gap;
    idx = '{i0, i1, i2, i3};
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    in_valid     <= 1'b1;
    in_command   <= cmd;
    in_range_dim <= rdim;
    in_step_in   <= step;
    in_index_0   <= i0;
    in_index_1   <= i1;
    in_index_2   <= i2;
    in_index_3   <= i3;
    do @(posedge clk); while (!in_ready);
    pending_offsets.push_back(predict_offset(cmd, rdim, step, idx));
  endtask

  // Lowers valid once the last item is taken, then waits for the results.
  task automatic drain;
    in_valid <= 1'b0;
    burst_left = 0;
    while (pending_offsets.size() != 0) @(posedge clk);
    repeat (DRAIN_GAP) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [63:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_NUM_DIMS:     dims_reg   = value[2:0];
      REG_COLUMN_MAJOR: colmaj_reg = value[0];
      REG_LOCAL_SIZES:  sizes_reg  = value;
      default:          ghosts_reg = value[31:0];
    endcase
  endtask

  task automatic set_config(logic [2:0] n, logic cm, logic [63:0] sz, logic [31:0] gh);
    write_reg(REG_NUM_DIMS, 64'(n));
    write_reg(REG_COLUMN_MAJOR, 64'(cm));
    write_reg(REG_LOCAL_SIZES, sz);
    write_reg(REG_GHOST_WIDTHS, 64'(gh));
  endtask

  function automatic logic signed [15:0] rand_index();
    case ($urandom_range(0, 3))
      0: return 16'($urandom_range(0, 40)) - 16'sd20;
      1: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      default: return 16'($urandom());
    endcase
  endfunction

  task automatic send_random(int count);
    for (int i = 0; i < count; i++) begin
      send_item(cmd_t'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                rand_index(), rand_index(), rand_index(), rand_index(), rand_index());
    end
  endtask

  // With the reset configuration: one dimension of zero extent, so indices
  // pass through unwrapped.
  task automatic test_reset_config;
    send_item(CMD_START, 2'd1, 16'sd5, 16'sh7fff, 16'sd0, 16'sd0, 16'sd0);
    send_item(CMD_START, 2'd1, 16'sd0, 16'sh8000, 16'sd0, 16'sd0, 16'sd0);
    send_item(CMD_STEP, 2'd0, 16'sh8000, 16'sd3, 16'sd3, 16'sd3, 16'sd3);
    drain();
  endtask

  // Directed corners: field extremes, both commands, every range dimension,
  // negative remainders, a range dimension outside the dimensions in use,
  // zero dimensions and more than four.
  task automatic test_directed;
    set_config(3'd4, 1'b0, 64'hffff_ffff_ffff_ffff, 32'hffff_ffff);
    send_item(CMD_START, 2'd0, 16'sd0, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
    send_item(CMD_START, 2'd3, 16'sd0, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
    send_item(CMD_STEP, 2'd0, 16'sh7fff, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
    send_item(CMD_STEP, 2'd0, 16'sh8000, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
    drain();
    set_config(3'd3, 1'b1, 64'h0000_0007_0000_0005, 32'h0003_0102);
    for (int rd = 0; rd < 4; rd++) begin
      send_item(CMD_START, 2'(rd), 16'sd0, -16'sd9, 16'sd4, -16'sd1, 16'sd2);
      send_item(CMD_STEP, 2'(rd), -16'sd3, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
    end
    drain();
    set_config(3'd0, 1'b0, 64'h0004_0004_0004_0004, 32'h0101_0101);
    send_item(CMD_START, 2'd0, 16'sd0, 16'sd7, 16'sd7, 16'sd7, 16'sd7);
    send_item(CMD_STEP, 2'd2, -16'sd11, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
    drain();
    set_config(3'd7, 1'b1, 64'h0003_0002_0000_0006, 32'h0200_0100);
    send_item(CMD_START, 2'd2, 16'sd0, -16'sd5, -16'sd2, -16'sd7, 16'sd9);
    send_item(CMD_STEP, 2'd3, 16'sd100, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
    drain();
  endtask

  // Random phases over a spread of configurations, mostly small extents so
  // wrapping matters, occasionally full-range registers.
  task automatic test_random;
    logic [63:0] sz;
    logic [31:0] gh;
    for (int p = 0; p < 12; p++) begin
      if (p % 4 == 3) begin
        sz = {$urandom(), $urandom()};
        gh = $urandom();
      end else begin
        sz = '0;
        gh = '0;
        for (int d = 0; d < 4; d++) begin
          sz[16*d +: 16] = 16'($urandom_range(0, 12));
          gh[8*d +: 8]   = 8'($urandom_range(0, 3));
        end
      end
      set_config(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)), sz, gh);
      stall_pattern_on = (p % 3 != 0);
      send_random(80);
      drain();
    end
  endtask

  // Receiver holds off for a long stretch while items keep coming, so the
  // chain fills and in_ready drops.
  task automatic test_backpressure;
    set_config(3'd4, 1'b0, 64'h0005_0003_0009_0002, 32'h0102_0001);
    holdoff_request = 200;
    send_random(60);
    drain();
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_command = CMD_START;
    in_range_dim = '0;
    in_step_in = '0;
    in_index_0 = '0;
    in_index_1 = '0;
    in_index_2 = '0;
    in_index_3 = '0;
    cfg_we = 1'b0;
    cfg_index = REG_NUM_DIMS;
    cfg_wdata = '0;
    error_count = 0;
    idle_cycles = 0;
    holdoff_request = 0;
    stall_pattern_on = 1'b1;
    burst_left = 0;
    dims_reg = 3'd1;
    colmaj_reg = 1'b0;
    sizes_reg = '0;
    ghosts_reg = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_config();
    test_directed();
    test_backpressure();
    test_random();

    if (error_count == 0) begin
      $display("ghosted_array_address_generator_test: done, clean");
    end else begin
      $display("ghosted_array_address_generator_test: done, errors");
    end
    $finish;
  end

endmodule
